FILE: rtl/pbsma_pkg.sv
// shared constants and types for the per-beam scan moving average
`default_nettype none
package pbsma_pkg;
	localparam int MAX_BEAMS = 1024;
	localparam int WINDOW = 10;
	localparam int RANGE_W = 16;

	localparam int BEAM_AW = (MAX_BEAMS > 1) ? $clog2(MAX_BEAMS) : 1;
	localparam int BEAM_CW = $clog2(MAX_BEAMS + 1);
	localparam int SLOT_W = $clog2(WINDOW);
	localparam int SEEN_W = $clog2(WINDOW + 2);

	localparam int HIST_DEPTH = WINDOW * MAX_BEAMS;
	localparam int HIST_AW = $clog2(HIST_DEPTH);

	localparam int SUM_W = $clog2(WINDOW * ((1 << RANGE_W) - 1) + 1);

	localparam int DIV_SHIFT = SUM_W + 4;
	localparam int RECIP_W = DIV_SHIFT + 1;
	localparam int RECIP = ((1 << DIV_SHIFT) + WINDOW - 1) / WINDOW;
	localparam int PROD_W = SUM_W + RECIP_W;

	localparam int QUEUE_DEPTH = 8;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

	typedef logic [RANGE_W-1:0] range_t;
	typedef logic [SUM_W-1:0] sum_t;

	typedef struct packed {
		logic valid;
		logic last;
	} res_ctl_t;
endpackage
`default_nettype wire

FILE: rtl/per_beam_scan_moving_average.sv
// top level: per-beam moving average of range samples over the last ten scans
// Takes one range sample per cycle while sample_ready is high, beams in order, with the
// final beam of each scan marked. History of all beams over ten scans sits in a
// 10240 x 16 memory and the running sums in a 1024 x 20 memory; each sample within the
// beam limit does one read-modify-write of both, with the new sum forwarded when the
// same beam comes back on the next cycle. After reset both memories are swept to zero,
// one history entry per cycle, with sample_ready low for the whole sweep. Results start
// once eleven scans have completed; a result passes through stage one and the divider
// stages and waits in an eight-entry queue offered on avg_valid; after the sweep
// sample_ready drops only when eight results are requested and not yet taken on avg_ready.
`default_nettype none
module per_beam_scan_moving_average (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     sample_valid,
	output logic                          sample_ready,
	input  wire logic [pbsma_pkg::RANGE_W-1:0] range_mm,
	input  wire logic                     last_in_scan,
	output logic                          avg_valid,
	input  wire logic                     avg_ready,
	output logic [pbsma_pkg::RANGE_W-1:0] avg_range_mm,
	output logic                          last_of_scan
);
	localparam int AW = pbsma_pkg::HIST_AW;
	localparam int BW = pbsma_pkg::BEAM_AW;
	localparam int CW = pbsma_pkg::QUEUE_CW;
	localparam int QW = pbsma_pkg::QUEUE_AW;

	pbsma_pkg::range_t hist_mem [pbsma_pkg::HIST_DEPTH];
	pbsma_pkg::sum_t sum_mem [pbsma_pkg::MAX_BEAMS];

	logic clr_q;
	logic [AW-1:0] clr_cnt_q;
	logic [pbsma_pkg::BEAM_CW-1:0] beam_q;
	logic [pbsma_pkg::SLOT_W-1:0] slot_q;
	logic [pbsma_pkg::SEEN_W-1:0] seen_q;
	logic [CW-1:0] cnt_q;

	logic accept, in_range, seen_full, produce, pop;
	logic [AW-1:0] pos;
	logic [BW-1:0] beam_idx;

	logic v_s1, res_s1, last_s1, fwd_s1;
	pbsma_pkg::range_t sample_s1;
	logic [AW-1:0] pos_s1;
	logic [BW-1:0] beam_s1;
	pbsma_pkg::sum_t fwd_sum_s1;
	pbsma_pkg::range_t hist_rd_q;
	pbsma_pkg::sum_t sum_rd_q;
	pbsma_pkg::sum_t base_sum, new_sum;
	logic [pbsma_pkg::SUM_W:0] sum_ext;

	pbsma_pkg::res_ctl_t div_in, div_out;
	pbsma_pkg::range_t div_quot;

	pbsma_pkg::range_t q_data [pbsma_pkg::QUEUE_DEPTH];
	logic q_last [pbsma_pkg::QUEUE_DEPTH];
	logic [QW-1:0] q_wr_q, q_rd_q;
	logic [CW-1:0] q_cnt_q;

	assign in_range = beam_q < pbsma_pkg::BEAM_CW'(pbsma_pkg::MAX_BEAMS);
	assign seen_full = seen_q >= pbsma_pkg::SEEN_W'(pbsma_pkg::WINDOW + 1);
	assign sample_ready = !clr_q && (cnt_q < CW'(pbsma_pkg::QUEUE_DEPTH));
	assign accept = sample_valid && sample_ready;
	assign produce = accept && in_range && seen_full;
	assign pop = avg_valid && avg_ready;
	assign beam_idx = beam_q[BW-1:0];
	assign pos = AW'(slot_q) * AW'(pbsma_pkg::MAX_BEAMS) + AW'(beam_idx);

	// scan position and warm-up tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beam_q <= '0;
			slot_q <= '0;
			seen_q <= '0;
		end else if (accept) begin
			if (last_in_scan) begin
				beam_q <= '0;
				slot_q <= (slot_q == pbsma_pkg::SLOT_W'(pbsma_pkg::WINDOW - 1)) ?
					'0 : slot_q + 1'b1;
				if (!seen_full)
					seen_q <= seen_q + 1'b1;
			end else if (in_range) begin
				beam_q <= beam_q + 1'b1;
			end
		end
	end

	// clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == AW'(pbsma_pkg::HIST_DEPTH - 1))
				clr_q <= 1'b0;
		end
	end

	// stage one control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			res_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			v_s1 <= accept && in_range;
			res_s1 <= produce;
			fwd_s1 <= accept && in_range && v_s1 && (beam_s1 == beam_idx);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= range_mm;
			last_s1 <= last_in_scan;
			pos_s1 <= pos;
			beam_s1 <= beam_idx;
			fwd_sum_s1 <= new_sum;
		end
	end

	assign base_sum = fwd_s1 ? fwd_sum_s1 : sum_rd_q;
	assign sum_ext = (pbsma_pkg::SUM_W + 1)'(base_sum) - (pbsma_pkg::SUM_W + 1)'(hist_rd_q)
		+ (pbsma_pkg::SUM_W + 1)'(sample_s1);
	assign new_sum = sum_ext[pbsma_pkg::SUM_W-1:0];

	// history memory
	always_ff @(posedge clk) begin
		if (clr_q)
			hist_mem[clr_cnt_q] <= '0;
		else if (v_s1)
			hist_mem[pos_s1] <= sample_s1;
		if (accept)
			hist_rd_q <= hist_mem[pos];
	end

	// running sum memory
	always_ff @(posedge clk) begin
		if (clr_q) begin
			if (clr_cnt_q < AW'(pbsma_pkg::MAX_BEAMS))
				sum_mem[clr_cnt_q[BW-1:0]] <= '0;
		end else if (v_s1) begin
			sum_mem[beam_s1] <= new_sum;
		end
		if (accept)
			sum_rd_q <= sum_mem[beam_idx];
	end

	assign div_in = '{valid: res_s1, last: last_s1};

	pbsma_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_i  (div_in),
		.sum_i  (new_sum),
		.ctl_o  (div_out),
		.quot_o (div_quot)
	);

	// results in flight, from request to delivery
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (produce && !pop)
			cnt_q <= cnt_q + 1'b1;
		else if (!produce && pop)
			cnt_q <= cnt_q - 1'b1;
	end

	// result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wr_q <= '0;
			q_rd_q <= '0;
			q_cnt_q <= '0;
		end else begin
			if (div_out.valid)
				q_wr_q <= q_wr_q + 1'b1;
			if (pop)
				q_rd_q <= q_rd_q + 1'b1;
			if (div_out.valid && !pop)
				q_cnt_q <= q_cnt_q + 1'b1;
			else if (!div_out.valid && pop)
				q_cnt_q <= q_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (div_out.valid) begin
			q_data[q_wr_q] <= div_quot;
			q_last[q_wr_q] <= div_out.last;
		end
	end

	assign avg_valid = q_cnt_q != '0;
	assign avg_range_mm = q_data[q_rd_q];
	assign last_of_scan = q_last[q_rd_q];

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(pbsma_pkg::QUEUE_DEPTH))
		else $error("results in flight exceed queue depth");

	a_queue_covered: assert property (@(posedge clk) disable iff (!arst_n)
		q_cnt_q <= cnt_q)
		else $error("queue holds more results than were requested");

	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_q |=> !clr_q)
		else $error("clearing sweep restarted");

	a_fwd_same_beam: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> $past(v_s1) && v_s1)
		else $error("sum forwarded without a back-to-back update");

	a_no_update_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !v_s1 && !res_s1)
		else $error("memory update during clearing sweep");
endmodule
`default_nettype wire

FILE: rtl/pbsma_div.sv
// two-stage reciprocal multiply that divides a beam sum by the window length
`default_nettype none
module pbsma_div (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire pbsma_pkg::res_ctl_t ctl_i,
	input  wire pbsma_pkg::sum_t     sum_i,
	output pbsma_pkg::res_ctl_t      ctl_o,
	output pbsma_pkg::range_t        quot_o
);
	localparam logic [pbsma_pkg::RECIP_W-1:0] RECIP_V = pbsma_pkg::RECIP_W'(pbsma_pkg::RECIP);

	pbsma_pkg::res_ctl_t ctl_s2, ctl_s3;
	pbsma_pkg::sum_t sum_s2;
	logic [pbsma_pkg::PROD_W-1:0] prod_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s2 <= ctl_i;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		sum_s2 <= sum_i;
		prod_s3 <= pbsma_pkg::PROD_W'(sum_s2) * pbsma_pkg::PROD_W'(RECIP_V);
	end

	assign ctl_o = ctl_s3;
	assign quot_o = prod_s3[pbsma_pkg::DIV_SHIFT +: pbsma_pkg::RANGE_W];
endmodule
`default_nettype wire

FILE: tb/per_beam_scan_moving_average_tb.sv
`timescale 1ns / 100ps
// testbench for the per-beam scan moving average, checked against a running-sum predictor
module per_beam_scan_moving_average_tb;
	localparam int STALL_PCT = 32;
	localparam int QUIET_LIMIT = 40000;
	localparam int RANDOM_ITEMS = 1400;
	localparam int CALM_FROM = 600;
	localparam int CALM_TO = 1000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		pbsma_pkg::range_t mm;
		logic last;
	} beam_rec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_ready;
	pbsma_pkg::range_t range_mm = '0;
	logic last_in_scan = 1'b0;
	logic avg_valid;
	logic avg_ready = 1'b0;
	pbsma_pkg::range_t avg_range_mm;
	logic last_of_scan;

	beam_rec_t scan_samples[$];
	beam_rec_t pending_avgs[$];

	pbsma_pkg::range_t hist_mm [pbsma_pkg::HIST_DEPTH];
	pbsma_pkg::sum_t beam_total [pbsma_pkg::MAX_BEAMS];
	int beam_pos = 0;
	int slot_pos = 0;
	int scans_done = 0;

	int failures = 0;
	int requests_taken = 0;
	int quiet_cycles = 0;
	logic req_taken = 1'b0;

	per_beam_scan_moving_average dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.range_mm(range_mm),
		.last_in_scan(last_in_scan),
		.avg_valid(avg_valid),
		.avg_ready(avg_ready),
		.avg_range_mm(avg_range_mm),
		.last_of_scan(last_of_scan)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	task automatic fold_sample(input beam_rec_t s);
		int pos;
		pbsma_pkg::sum_t total;
		beam_rec_t res;
		if (beam_pos < pbsma_pkg::MAX_BEAMS) begin
			pos = slot_pos * pbsma_pkg::MAX_BEAMS + beam_pos;
			total = beam_total[beam_pos] - pbsma_pkg::sum_t'(hist_mm[pos])
				+ pbsma_pkg::sum_t'(s.mm);
			hist_mm[pos] = s.mm;
			beam_total[beam_pos] = total;
			if (scans_done >= pbsma_pkg::WINDOW + 1) begin
				res.mm = pbsma_pkg::range_t'(total / pbsma_pkg::WINDOW);
				res.last = s.last;
				pending_avgs.push_back(res);
			end
			beam_pos++;
		end
		if (s.last) begin
			beam_pos = 0;
			slot_pos = (slot_pos + 1) % pbsma_pkg::WINDOW;
			if (scans_done < pbsma_pkg::WINDOW + 1)
				scans_done++;
		end
	endtask

	function automatic pbsma_pkg::range_t pick_mm();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return pbsma_pkg::range_t'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic add_sample(input pbsma_pkg::range_t mm, input logic last);
		beam_rec_t s;
		s.mm = mm;
		s.last = last;
		scan_samples.push_back(s);
	endtask

	task automatic add_scan(input int beams);
		for (int i = 0; i < beams; i++)
			add_sample(pick_mm(), i == beams - 1);
	endtask

	initial begin
		int cur_beams;
		int random_count;
		bit big_done;
		foreach (hist_mm[i])
			hist_mm[i] = '0;
		foreach (beam_total[i])
			beam_total[i] = '0;

		// warm-up with full-scale and zero beams, then beam count changes
		for (int k = 0; k < pbsma_pkg::WINDOW + 1; k++) begin
			add_sample('1, 1'b0);
			add_sample('0, 1'b1);
		end
		add_sample('1, 1'b1);
		add_sample('0, 1'b0);
		add_sample('1, 1'b0);
		add_sample(pbsma_pkg::range_t'(16'h5555), 1'b1);

		cur_beams = 4;
		random_count = 0;
		big_done = 1'b0;
		while (random_count < RANDOM_ITEMS) begin
			if ($urandom_range(0, 5) == 0)
				cur_beams = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 40)
					: $urandom_range(1, 8);
			if (!big_done && random_count >= RANDOM_ITEMS / 4) begin
				// scan running past the beam limit, last mark on a dropped beam
				add_scan(pbsma_pkg::MAX_BEAMS + 2);
				random_count += pbsma_pkg::MAX_BEAMS + 2;
				big_done = 1'b1;
			end else begin
				add_scan(cur_beams);
				random_count += cur_beams;
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (scan_samples.size() != 0 || sample_valid)
			@(posedge clk);
		while (pending_avgs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	always @(negedge clk) begin
		beam_rec_t nxt;
		logic calm;
		calm = requests_taken >= CALM_FROM && requests_taken < CALM_TO;
		avg_ready <= arst_n && (calm || $urandom_range(0, 99) >= STALL_PCT);
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else if (!sample_valid || req_taken) begin
			if (scan_samples.size() != 0 && (calm || $urandom_range(0, 99) >= STALL_PCT)) begin
				nxt = scan_samples.pop_front();
				sample_valid <= 1'b1;
				range_mm <= nxt.mm;
				last_in_scan <= nxt.last;
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		beam_rec_t req;
		beam_rec_t want;
		logic res_taken;
		req_taken = arst_n && sample_valid && sample_ready;
		res_taken = arst_n && avg_valid && avg_ready;
		if (req_taken) begin
			req.mm = range_mm;
			req.last = last_in_scan;
			fold_sample(req);
			requests_taken++;
		end
		if (res_taken) begin
			if (pending_avgs.size() == 0) begin
				failures++;
				$error("unexpected result: avg_range_mm %0d last_of_scan %0b",
					avg_range_mm, last_of_scan);
			end else begin
				want = pending_avgs.pop_front();
				if (avg_range_mm !== want.mm) begin
					failures++;
					$error("avg_range_mm: expected %0d, got %0d", want.mm, avg_range_mm);
				end
				if (last_of_scan !== want.last) begin
					failures++;
					$error("last_of_scan: expected %0b, got %0b", want.last, last_of_scan);
				end
			end
		end
		if (!arst_n || req_taken || res_taken)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end
endmodule

FILE: sim.f
rtl/pbsma_pkg.sv
rtl/pbsma_div.sv
rtl/per_beam_scan_moving_average.sv
tb/per_beam_scan_moving_average_tb.sv
